// ===== rtl/satq_pkg.sv =====
// ----------------------------------------------------------------------------
// satq_pkg
// Shared codes, widths and defaults for the sorted alarm timer queue.
// ----------------------------------------------------------------------------
package satq_pkg;

  localparam int ALARM_COUNT_DEF = 16;
  localparam int TIME_WIDTH_DEF  = 64;

  localparam int ID_W     = 4;
  localparam int FTIME_W  = 64;
  localparam int CMD_W    = 2;
  localparam int KIND_W   = 3;
  localparam int IN_W     = 136;
  localparam int OUT_W    = 72;

  typedef enum logic [CMD_W-1:0] {
    CMD_BASE  = 2'd0,
    CMD_SLEEP = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    K_BASE    = 3'd0,
    K_ARMED   = 3'd1,
    K_PAST    = 3'd2,
    K_REJECT  = 3'd3,
    K_EXPIRED = 3'd4,
    K_DONE    = 3'd5
  } kind_t;

endpackage

// ===== rtl/sorted_alarm_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue
// Per-alarm wake bases plus a wake-time sorted queue of pending alarms,
// walked one entry at a time by a small sequencer over one queue RAM port.
// ----------------------------------------------------------------------------
// A base set or reject loads the result register. A sleep adds base and delay,
// checks it against now and, unless past or full, walks the queue from the
// tail, moving later-waking entries back a slot. A tick emits a result per
// expired alarm, moves the rest up and emits done. A full result register
// holds the sequencer. One request at a time; s_tready is high only while idle.
// Reset (rst, synchronous): queue empty, bases zero, compare all ones, irq off.
module sorted_alarm_timer_queue #(
  parameter int ALARM_COUNT = satq_pkg::ALARM_COUNT_DEF,
  parameter int TIME_WIDTH  = satq_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // alarm_id[3:0], delay_ticks[67:4], now[131:68], zero pad
  input  logic [satq_pkg::IN_W-1:0]   s_tdata,
  // command[1:0]
  input  logic [satq_pkg::CMD_W-1:0]  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // alarm_id_out[3:0], compare_value[67:4], irq_enable[68], zero pad
  output logic [satq_pkg::OUT_W-1:0]  m_tdata,
  // kind[2:0]
  output logic [satq_pkg::KIND_W-1:0] m_tuser,
  output logic                        m_tlast
);
  import satq_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int IW = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
  localparam int CW = $clog2(ALARM_COUNT + 1);
  localparam logic [TW-1:0] TMASK = '1;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_ADD  = 12'b000000000010,
    S_CMP  = 12'b000000000100,
    S_IRD  = 12'b000000001000,
    S_ICMP = 12'b000000010000,
    S_IWR  = 12'b000000100000,
    S_RES  = 12'b000001000000,
    S_TRD  = 12'b000010000000,
    S_TCHK = 12'b000100000000,
    S_SRD  = 12'b001000000000,
    S_SWR  = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_t;

  state_t state;

  logic [TW-1:0]   base_mem [ALARM_COUNT];
  logic            base_vld [ALARM_COUNT];
  logic            pending  [ALARM_COUNT];
  logic [TW-1:0]   qt_mem   [ALARM_COUNT];
  logic [ID_W-1:0] qi_mem   [ALARM_COUNT];

  logic [ID_W-1:0] id_r;
  logic [TW-1:0]   delay_r, now_r, wake, head_time, compare, base_rd, q_rd_time;
  logic            base_rd_vld, irq_on;
  logic [ID_W-1:0] q_rd_id;
  logic [CW-1:0]   count, ptr, jdx;
  kind_t           res_kind;

  logic            out_valid, out_irq, out_last;
  kind_t           out_kind;
  logic [ID_W-1:0] out_id;
  logic [TW-1:0]   out_cmp;

  logic [ID_W-1:0] in_id;
  logic [TW-1:0]   in_delay, in_now;
  logic [IW-1:0]   in_addr, id_addr, rd_addr;
  logic            in_bad, accept, out_free;
  logic [TW:0]     sum;
  logic [CW-1:0]   ptr_m1, jdx_sub, remain;

  logic            base_we;
  logic [IW-1:0]   base_waddr;
  logic [TW-1:0]   base_wdata;
  logic            q_re, q_we;
  logic [IW-1:0]   q_raddr, q_waddr;
  logic [TW-1:0]   q_wtime;
  logic [ID_W-1:0] q_wid;

  logic            emit;
  kind_t           emit_kind;
  logic [ID_W-1:0] emit_id;
  logic [TW-1:0]   emit_cmp;
  logic            emit_irq, emit_last;

  assign in_id    = s_tdata[3:0];
  assign in_delay = s_tdata[4 +: TW];
  assign in_now   = s_tdata[68 +: TW];
  assign in_addr  = IW'(in_id);
  assign id_addr  = IW'(id_r);
  assign rd_addr  = IW'(q_rd_id);
  assign in_bad   = 32'(in_id) >= ALARM_COUNT;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign sum      = {1'b0, base_rd_vld ? base_rd : {TW{1'b0}}} + {1'b0, delay_r};
  assign ptr_m1   = ptr - 1'b1;
  assign jdx_sub  = jdx - ptr;
  assign remain   = count - ptr;

  always_comb begin
    base_we    = 1'b0;
    base_waddr = id_addr;
    base_wdata = wake;
    q_re       = 1'b0;
    q_raddr    = ptr[IW-1:0];
    q_we       = 1'b0;
    q_waddr    = ptr[IW-1:0];
    q_wtime    = q_rd_time;
    q_wid      = q_rd_id;
    emit       = 1'b0;
    emit_kind  = res_kind;
    emit_id    = id_r;
    emit_cmp   = compare;
    emit_irq   = irq_on;
    emit_last  = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept && s_tuser == CMD_BASE && !in_bad) begin
          base_we    = 1'b1;
          base_waddr = in_addr;
          base_wdata = in_now;
        end
      end
      S_CMP: base_we = 1'b1;
      S_IRD: begin
        q_re    = (ptr != '0);
        q_raddr = ptr_m1[IW-1:0];
      end
      S_ICMP: q_we = (q_rd_time > wake);
      S_IWR: begin
        q_we      = out_free;
        q_wtime   = wake;
        q_wid     = id_r;
        emit      = out_free;
        emit_kind = K_ARMED;
        emit_cmp  = (ptr == '0) ? wake : compare;
        emit_irq  = 1'b1;
      end
      S_RES: emit = out_free;
      S_TRD: q_re = (ptr < count);
      S_TCHK: begin
        if (q_rd_time <= now_r) begin
          emit       = out_free;
          emit_kind  = K_EXPIRED;
          emit_id    = q_rd_id;
          emit_last  = 1'b0;
          base_we    = out_free && (32'(q_rd_id) < ALARM_COUNT);
          base_waddr = rd_addr;
          base_wdata = now_r;
        end
      end
      S_SRD: begin
        q_re    = (ptr != '0) && (jdx < count);
        q_raddr = jdx[IW-1:0];
      end
      S_SWR: begin
        q_we    = 1'b1;
        q_waddr = jdx_sub[IW-1:0];
      end
      S_DONE: begin
        emit      = out_free;
        emit_kind = K_DONE;
        emit_id   = '0;
        emit_cmp  = (remain != '0) ? head_time : TMASK;
        emit_irq  = (remain != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (base_we) base_mem[base_waddr] <= base_wdata;
    if (state == S_IDLE) base_rd <= base_mem[in_addr];
    if (q_we) begin
      qt_mem[q_waddr] <= q_wtime;
      qi_mem[q_waddr] <= q_wid;
    end
    if (q_re) begin
      q_rd_time <= qt_mem[q_raddr];
      q_rd_id   <= qi_mem[q_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ALARM_COUNT; k++) begin
        base_vld[k] <= 1'b0;
        pending[k]  <= 1'b0;
      end
      base_rd_vld <= 1'b0;
    end else begin
      if (state == S_IDLE) base_rd_vld <= base_vld[in_addr];
      if (base_we) base_vld[base_waddr] <= 1'b1;
      if (state == S_CMP && wake >= now_r) pending[id_addr] <= 1'b1;
      if (base_we && state == S_TCHK) pending[base_waddr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      compare   <= TMASK;
      irq_on    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        out_kind  <= emit_kind;
        out_id    <= emit_id;
        out_cmp   <= emit_cmp;
        out_irq   <= emit_irq;
        out_last  <= emit_last;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            id_r    <= in_id;
            delay_r <= in_delay;
            now_r   <= in_now;
            ptr     <= '0;
            case (s_tuser)
              CMD_BASE, CMD_SLEEP: begin
                if (in_bad || (s_tuser == CMD_SLEEP && pending[in_addr])) begin
                  res_kind <= K_REJECT;
                  state    <= S_RES;
                end else if (s_tuser == CMD_BASE) begin
                  res_kind <= K_BASE;
                  state    <= S_RES;
                end else begin
                  state <= S_ADD;
                end
              end
              CMD_TICK: state <= S_TRD;
              default: ;
            endcase
          end
        end
        S_ADD: begin
          wake  <= sum[TW] ? TMASK : sum[TW-1:0];
          state <= S_CMP;
        end
        S_CMP: begin
          if (wake < now_r) begin
            res_kind <= K_PAST;
            state    <= S_RES;
          end else if (32'(count) >= ALARM_COUNT) begin
            res_kind <= K_ARMED;
            state    <= S_RES;
          end else begin
            ptr   <= count;
            state <= S_IRD;
          end
        end
        S_IRD: state <= (ptr == '0) ? S_IWR : S_ICMP;
        S_ICMP: begin
          if (q_rd_time > wake) begin
            ptr   <= ptr_m1;
            state <= S_IRD;
          end else begin
            state <= S_IWR;
          end
        end
        S_IWR: begin
          if (out_free) begin
            count  <= count + 1'b1;
            if (ptr == '0) compare <= wake;
            irq_on <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_RES: if (out_free) state <= S_IDLE;
        S_TRD: begin
          if (ptr < count) begin
            state <= S_TCHK;
          end else begin
            jdx   <= ptr;
            state <= S_SRD;
          end
        end
        S_TCHK: begin
          if (q_rd_time <= now_r) begin
            if (out_free) begin
              ptr   <= ptr + 1'b1;
              state <= S_TRD;
            end
          end else begin
            head_time <= q_rd_time;
            jdx       <= ptr;
            state     <= S_SRD;
          end
        end
        S_SRD: state <= ((ptr != '0) && (jdx < count)) ? S_SWR : S_DONE;
        S_SWR: begin
          jdx   <= jdx + 1'b1;
          state <= S_SRD;
        end
        S_DONE: begin
          if (out_free) begin
            count   <= remain;
            compare <= (remain != '0) ? head_time : TMASK;
            irq_on  <= (remain != '0);
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {3'b000, out_irq, FTIME_W'(out_cmp), out_id};

endmodule

// ===== rtl/satq_checker.sv =====
// ----------------------------------------------------------------------------
// satq_checker
// Port-level checks for the sorted alarm timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module satq_checker #(
  parameter int TIME_WIDTH = satq_pkg::TIME_WIDTH_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [satq_pkg::IN_W-1:0]   s_tdata,
  input logic [satq_pkg::CMD_W-1:0]  s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [satq_pkg::OUT_W-1:0]  m_tdata,
  input logic [satq_pkg::KIND_W-1:0] m_tuser,
  input logic                        m_tlast
);
  import satq_pkg::*;

  localparam logic [FTIME_W-1:0] EMPTY_CMP = FTIME_W'({TIME_WIDTH{1'b1}});

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result dropped while stalled");

  a_exp_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == K_EXPIRED |-> !m_tlast)
    else $error("expired result marked last");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == K_DONE && !m_tdata[68] |-> m_tdata[67:4] == EMPTY_CMP)
    else $error("empty queue without all-ones compare");

  a_done_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == K_DONE |-> m_tlast && m_tdata[3:0] == '0)
    else $error("tick done result malformed");

endmodule

bind sorted_alarm_timer_queue satq_checker #(.TIME_WIDTH(TIME_WIDTH)) u_satq_checker (.*);
